// File: rtl/core/priority_task_scheduler_assert.svh
// Assertion macros for the task scheduler.
`ifndef PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/pts_pkg.sv
// Types, constants and helpers for the task scheduler.
package pts_pkg;

	localparam int NUM_TASKS = 16;
	localparam int NUM_PRIOS = 32;
	localparam int TID_W = $clog2(NUM_TASKS);
	localparam int PRIO_W = $clog2(NUM_PRIOS);
	localparam int CNT_W = $clog2(NUM_TASKS + 1);
	localparam logic [7:0] SAT_MAX = 8'd255;
	localparam logic [7:0] SLICE_RESET = 8'd10;

	localparam int FLAG_VALID = 0;
	localparam int FLAG_DELAYED = 1;
	localparam int FLAG_SUSPENDED = 2;

	typedef enum logic [2:0] {
		ACT_ADD, ACT_TICK, ACT_DELAY, ACT_SUSPEND, ACT_WAKE, ACT_LOCK, ACT_UNLOCK, ACT_NONE
	} action_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_MR, S_UR_START, S_UR_WALK, S_TK_DEC, S_TK_WAKE, S_TK_SLICE,
		S_DI_WALK, S_FIND
	} state_t;

	typedef struct packed {
		logic [TID_W-1:0] head;
		logic [TID_W-1:0] tail;
		logic [CNT_W-1:0] count;
	} queue_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [PRIO_W-1:0] lowest_bit(input logic [NUM_PRIOS-1:0] v);
		logic [PRIO_W-1:0] r;
		r = '0;
		for (int i = NUM_PRIOS - 1; i >= 0; i--) begin
			if (v[i]) r = PRIO_W'(i);
		end
		return r;
	endfunction

endpackage

// File: rtl/core/priority_task_scheduler.sv
// Event-driven task scheduler with priority ready queues and a delta delay list.
//
//   channel | signals                                         | role
//   in      | in_valid, in_ready, action, task_id, ...        | one event per transfer
//   out     | out_valid, out_ready, next_task, switch_request | one result per event
//   cfg     | cfg_we, cfg_wdata                               | slice length write
//
// An event holds the block until its sequence ends: the sequencer walks a ready queue or the delay
// list one entry per cycle, so the length of the walked list sets how long the block is held. Each
// task that a tick wakes adds a pass through S_MR and back through S_TK_WAKE.
// Reset is asynchronous; no clearing pass is needed. in_ready is high only in the idle state.
// A result waiting on out_ready holds the sequencer in its final step.
`include "priority_task_scheduler_assert.svh"

module priority_task_scheduler import pts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [3:0]  task_id,
	input  logic [4:0]  priority_req,
	input  logic [31:0] delay_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  next_task,
	output logic        switch_request,
	output logic        none_ready,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	state_t state_q, state_d;

	action_t           op_act_q;
	logic [TID_W-1:0]  op_tid_q;
	logic [PRIO_W-1:0] op_pri_q;
	logic [31:0]       op_dly_q;
	logic              sched_q;

	logic [TID_W-1:0] mr_task_q, ur_task_q, ur_cur_q, ur_prev_q;
	state_t           mr_next_q, ur_next_q;
	logic [CNT_W-1:0] ur_i_q;

	logic [TID_W-1:0] dl_head_q;
	logic [CNT_W-1:0] dl_count_q;
	logic [32:0]      di_sum_q;
	logic [TID_W-1:0] di_cur_q, di_prev_q;
	logic [CNT_W-1:0] di_i_q;

	logic [TID_W-1:0]     current_q;
	logic [7:0]           lock_q;
	logic [7:0]           slice_len_q;
	logic [NUM_PRIOS-1:0] bitmap_q;

	logic [PRIO_W-1:0] task_prio_q [NUM_TASKS];
	logic [2:0]        task_flags_q [NUM_TASKS];
	logic [7:0]        susp_q [NUM_TASKS];
	queue_t            queue_q [NUM_PRIOS];
	logic [7:0]        slice_left_q [NUM_TASKS];
	logic [31:0]       delta_q [NUM_TASKS];
	logic [TID_W-1:0]  dlink_q [NUM_TASKS];
	logic [TID_W-1:0]  rlink_q [NUM_TASKS];

	logic             out_valid_q, sw_q, none_q;
	logic [TID_W-1:0] next_q;

	// Shared read selects, one address per store in any cycle.
	logic [TID_W-1:0]  fl_idx, pr_idx, dd_idx;
	logic [PRIO_W-1:0] q_idx, find_p;
	logic [2:0]        fl_rd;
	queue_t            q_rd;
	logic [31:0]       dd_rd;
	logic [TID_W-1:0]  dl_rd;
	logic [32:0]       di_nsum;
	logic [31:0]       di_d;
	logic [7:0]        sc_rd, sc_inc, sc_dec, sl_dec;
	logic              cur_ready, tk_pop, di_hit, find_go;
	logic [TID_W-1:0]  best;

	always_comb begin
		case (state_q)
			S_TK_WAKE:  fl_idx = dl_head_q;
			S_TK_SLICE: fl_idx = current_q;
			S_DISPATCH: fl_idx = (op_act_q == ACT_DELAY) ? current_q : op_tid_q;
			default:    fl_idx = current_q;
		endcase
		pr_idx = (state_q == S_MR) ? mr_task_q : ur_task_q;
		dd_idx = (state_q == S_DI_WALK) ? di_cur_q : dl_head_q;
		find_p = lowest_bit(bitmap_q);
		q_idx = (state_q == S_FIND) ? find_p : task_prio_q[pr_idx];
	end

	assign fl_rd = task_flags_q[fl_idx];
	assign q_rd = queue_q[q_idx];
	assign dd_rd = delta_q[dd_idx];
	assign dl_rd = dlink_q[dd_idx];
	assign sc_rd = susp_q[op_tid_q];
	assign sc_inc = (sc_rd < SAT_MAX) ? sc_rd + 8'd1 : sc_rd;
	assign sc_dec = (sc_rd != 8'd0) ? sc_rd - 8'd1 : sc_rd;
	assign sl_dec = slice_left_q[current_q] - 8'd1;
	assign cur_ready = fl_rd[FLAG_VALID] && !fl_rd[FLAG_DELAYED] && !fl_rd[FLAG_SUSPENDED];
	assign tk_pop = (dl_count_q != '0) && (dd_rd == 32'd0);
	assign di_nsum = di_sum_q + {1'b0, dd_rd};
	assign di_hit = (di_i_q < dl_count_q) && (di_nsum > {1'b0, op_dly_q});
	assign di_d = op_dly_q - di_sum_q[31:0];
	assign find_go = !out_valid_q || out_ready;
	assign best = (bitmap_q != '0) ? q_rd.head : current_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:
				if (in_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				state_d = S_FIND;
				case (op_act_q)
					ACT_ADD:     if (!fl_rd[FLAG_VALID]) state_d = S_MR;
					ACT_TICK:    state_d = S_TK_DEC;
					ACT_DELAY:   if (cur_ready) state_d = S_DI_WALK;
					ACT_SUSPEND: if (fl_rd[FLAG_VALID] && !fl_rd[FLAG_DELAYED] && sc_inc == 8'd1)
						state_d = S_UR_START;
					ACT_WAKE:    if (fl_rd[FLAG_SUSPENDED] && sc_dec == 8'd0) state_d = S_MR;
					default:     state_d = S_FIND;
				endcase
			end
			S_MR:       state_d = mr_next_q;
			S_UR_START: state_d = S_UR_WALK;
			S_UR_WALK:
				if (ur_i_q >= q_rd.count || ur_cur_q == ur_task_q) state_d = ur_next_q;
			S_TK_DEC:   state_d = S_TK_WAKE;
			S_TK_WAKE:  state_d = tk_pop ? S_MR : S_TK_SLICE;
			S_TK_SLICE:
				if (fl_rd[FLAG_VALID] && sl_dec == 8'd0 && cur_ready) state_d = S_UR_START;
				else state_d = S_FIND;
			S_DI_WALK:
				if (di_hit || di_i_q >= dl_count_q) state_d = S_UR_START;
			S_FIND:
				if (find_go) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready = (state_q == S_IDLE);
		out_valid = out_valid_q;
		next_task = next_q;
		switch_request = sw_q;
		none_ready = none_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sched_q <= 1'b0;
			op_act_q <= ACT_NONE;
			dl_head_q <= '0;
			dl_count_q <= '0;
			current_q <= '0;
			lock_q <= '0;
			slice_len_q <= SLICE_RESET;
			bitmap_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				task_prio_q[i] <= '0;
				task_flags_q[i] <= '0;
				susp_q[i] <= '0;
			end
			for (int i = 0; i < NUM_PRIOS; i++) queue_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) slice_len_q <= (cfg_wdata == 8'd0) ? 8'd1 : cfg_wdata;
			// In the final step a new result takes the place of the one being transferred.
			if (out_valid_q && out_ready && state_q != S_FIND) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:
					if (in_valid) begin
						op_act_q <= action_t'(action);
						sched_q <= 1'b0;
					end
				S_DISPATCH:
					case (op_act_q)
						ACT_ADD:
							if (!fl_rd[FLAG_VALID]) begin
								task_prio_q[op_tid_q] <= op_pri_q;
								task_flags_q[op_tid_q] <= 3'b001;
								susp_q[op_tid_q] <= '0;
								mr_task_q <= op_tid_q;
								mr_next_q <= S_FIND;
							end
						ACT_TICK: sched_q <= 1'b1;
						ACT_DELAY: begin
							sched_q <= 1'b1;
							di_sum_q <= '0;
							di_cur_q <= dl_head_q;
							di_prev_q <= '0;
							di_i_q <= '0;
						end
						ACT_SUSPEND:
							if (fl_rd[FLAG_VALID] && !fl_rd[FLAG_DELAYED]) begin
								susp_q[op_tid_q] <= sc_inc;
								if (sc_inc == 8'd1) begin
									task_flags_q[op_tid_q][FLAG_SUSPENDED] <= 1'b1;
									ur_task_q <= op_tid_q;
									ur_next_q <= S_FIND;
									sched_q <= (op_tid_q == current_q);
								end
							end
						ACT_WAKE:
							if (fl_rd[FLAG_SUSPENDED]) begin
								susp_q[op_tid_q] <= sc_dec;
								if (sc_dec == 8'd0) begin
									task_flags_q[op_tid_q][FLAG_SUSPENDED] <= 1'b0;
									mr_task_q <= op_tid_q;
									mr_next_q <= S_FIND;
									sched_q <= 1'b1;
								end
							end
						ACT_LOCK:
							if (lock_q < SAT_MAX) lock_q <= lock_q + 8'd1;
						ACT_UNLOCK:
							if (lock_q != 8'd0) begin
								lock_q <= lock_q - 8'd1;
								sched_q <= (lock_q == 8'd1);
							end
						default: ;
					endcase
				S_MR: begin
					if (q_rd.count == '0) queue_q[q_idx].head <= mr_task_q;
					queue_q[q_idx].tail <= mr_task_q;
					queue_q[q_idx].count <= q_rd.count + CNT_W'(1);
					bitmap_q[q_idx] <= 1'b1;
				end
				S_UR_START: begin
					ur_cur_q <= q_rd.head;
					ur_prev_q <= '0;
					ur_i_q <= '0;
				end
				S_UR_WALK:
					if (ur_i_q < q_rd.count && ur_cur_q == ur_task_q) begin
						if (ur_i_q == '0) queue_q[q_idx].head <= rlink_q[ur_cur_q];
						if (ur_i_q + CNT_W'(1) == q_rd.count) queue_q[q_idx].tail <= ur_prev_q;
						queue_q[q_idx].count <= q_rd.count - CNT_W'(1);
						if (q_rd.count == CNT_W'(1)) bitmap_q[q_idx] <= 1'b0;
					end else if (ur_i_q < q_rd.count) begin
						ur_prev_q <= ur_cur_q;
						ur_cur_q <= rlink_q[ur_cur_q];
						ur_i_q <= ur_i_q + CNT_W'(1);
					end else begin
						if (q_rd.count == '0) bitmap_q[q_idx] <= 1'b0;
					end
				S_TK_WAKE:
					if (tk_pop) begin
						dl_head_q <= dl_rd;
						dl_count_q <= dl_count_q - CNT_W'(1);
						task_flags_q[dl_head_q][FLAG_DELAYED] <= 1'b0;
						mr_task_q <= dl_head_q;
						mr_next_q <= S_TK_WAKE;
					end
				S_TK_SLICE:
					if (fl_rd[FLAG_VALID] && sl_dec == 8'd0 && cur_ready) begin
						ur_task_q <= current_q;
						ur_next_q <= S_MR;
						mr_task_q <= current_q;
						mr_next_q <= S_FIND;
					end
				S_DI_WALK:
					if (di_hit || di_i_q >= dl_count_q) begin
						if (di_hit ? (di_i_q == '0) : (dl_count_q == '0)) dl_head_q <= current_q;
						dl_count_q <= dl_count_q + CNT_W'(1);
						task_flags_q[current_q][FLAG_DELAYED] <= 1'b1;
						ur_task_q <= current_q;
						ur_next_q <= S_FIND;
					end else begin
						di_sum_q <= di_nsum;
						di_prev_q <= di_cur_q;
						di_cur_q <= dl_rd;
						di_i_q <= di_i_q + CNT_W'(1);
					end
				S_FIND:
					if (find_go) begin
						out_valid_q <= 1'b1;
						next_q <= best;
						none_q <= (bitmap_q == '0);
						sw_q <= (bitmap_q != '0) && sched_q && lock_q == 8'd0 && best != current_q;
						if ((bitmap_q != '0) && sched_q && lock_q == 8'd0) current_q <= best;
					end
				default: ;
			endcase
		end
	end

	// Input payload capture and the stores that have no reset value.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_tid_q <= task_id;
			op_pri_q <= priority_req;
			op_dly_q <= delay_ticks;
		end
		case (state_q)
			S_DISPATCH:
				if (op_act_q == ACT_ADD && !fl_rd[FLAG_VALID])
					slice_left_q[op_tid_q] <= slice_len_q;
			S_MR:
				if (q_rd.count != '0) rlink_q[q_rd.tail] <= mr_task_q;
			S_UR_WALK:
				if (ur_i_q < q_rd.count && ur_cur_q == ur_task_q && ur_i_q != '0)
					rlink_q[ur_prev_q] <= rlink_q[ur_cur_q];
			S_TK_DEC:
				if (dl_count_q != '0 && dd_rd != 32'd0) delta_q[dl_head_q] <= dd_rd - 32'd1;
			S_TK_SLICE:
				if (fl_rd[FLAG_VALID])
					slice_left_q[current_q] <= (sl_dec == 8'd0) ? slice_len_q : sl_dec;
			S_DI_WALK:
				if (di_hit) begin
					delta_q[current_q] <= di_d;
					delta_q[di_cur_q] <= dd_rd - di_d;
					dlink_q[current_q] <= di_cur_q;
					if (di_i_q != '0) dlink_q[di_prev_q] <= current_q;
				end else if (di_i_q >= dl_count_q) begin
					delta_q[current_q] <= di_d;
					dlink_q[current_q] <= '0;
					if (dl_count_q != '0) dlink_q[di_prev_q] <= current_q;
				end
			default: ;
		endcase
	end

	`PTS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	`PTS_ASSERT_IMP(a_switch_has_task, out_valid && switch_request, !none_ready,
		"switch with no ready task")
	`PTS_ASSERT_IMP(a_switch_sets_current, out_valid && switch_request, next_task == current_q,
		"switch target not current")

endmodule

// File: sim/tb_priority_task_scheduler.sv
// Self-checking testbench for the priority task scheduler with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_priority_task_scheduler import pts_pkg::*; ();

	typedef struct {
		logic [3:0] next_task;
		logic       switch_request;
		logic       none_ready;
	} sched_result_t;

	class sched_scoreboard;
		logic [4:0]  prio [16];
		logic [2:0]  flags [16];
		logic [7:0]  susp [16];
		logic [7:0]  slice [16];
		logic [31:0] sleep_delta [16];
		logic [3:0]  sleep_link [16];
		logic [3:0]  sleep_head;
		int          sleep_count;
		logic [3:0]  ready_link [16];
		logic [3:0]  q_head [32];
		logic [3:0]  q_tail [32];
		int          q_count [32];
		logic [31:0] bitmap;
		logic [3:0]  running;
		logic [7:0]  locks;
		logic [7:0]  slice_len;
		sched_result_t pending [$];
		int errors;
		int results_seen;
		int switches_seen;

		function new();
			for (int i = 0; i < 16; i++) begin
				prio[i] = '0; flags[i] = '0; susp[i] = '0; slice[i] = '0;
				sleep_delta[i] = '0; sleep_link[i] = '0; ready_link[i] = '0;
			end
			for (int p = 0; p < 32; p++) begin
				q_head[p] = '0; q_tail[p] = '0; q_count[p] = 0;
			end
			sleep_head = '0; sleep_count = 0; bitmap = '0; running = '0; locks = '0;
			slice_len = SLICE_RESET; errors = 0; results_seen = 0; switches_seen = 0;
		endfunction

		function void set_slice(logic [7:0] v);
			slice_len = (v == 0) ? 8'd1 : v;
		endfunction

		function void enqueue(logic [3:0] t);
			logic [4:0] p;
			p = prio[t];
			if (q_count[p] == 0) q_head[p] = t;
			else ready_link[q_tail[p]] = t;
			q_tail[p] = t;
			q_count[p]++;
			bitmap[p] = 1'b1;
		endfunction

		function void dequeue(logic [3:0] t);
			logic [4:0] p;
			logic [3:0] prev, cur;
			p = prio[t];
			prev = '0;
			cur = q_head[p];
			for (int i = 0; i < q_count[p]; i++) begin
				if (cur == t) begin
					if (i == 0) q_head[p] = ready_link[cur];
					else ready_link[prev] = ready_link[cur];
					if (i + 1 == q_count[p]) q_tail[p] = prev;
					q_count[p]--;
					break;
				end
				prev = cur;
				cur = ready_link[cur];
			end
			if (q_count[p] == 0) bitmap[p] = 1'b0;
		endfunction

		// Entries hold their ticks beyond the predecessor; only the successor is reduced.
		function void sleep_insert(logic [3:0] t, logic [31:0] ticks);
			longint sum, prior;
			logic [3:0] prev, cur;
			logic [31:0] d;
			sum = 0;
			prev = '0;
			cur = sleep_head;
			for (int i = 0; i < sleep_count; i++) begin
				prior = sum;
				sum += sleep_delta[cur];
				if (sum > longint'(ticks)) begin
					d = 32'(longint'(ticks) - prior);
					sleep_delta[t] = d;
					sleep_delta[cur] -= d;
					sleep_link[t] = cur;
					if (i == 0) sleep_head = t;
					else sleep_link[prev] = t;
					sleep_count++;
					flags[t][FLAG_DELAYED] = 1'b1;
					return;
				end
				prev = cur;
				cur = sleep_link[cur];
			end
			sleep_delta[t] = 32'(longint'(ticks) - sum);
			sleep_link[t] = '0;
			if (sleep_count == 0) sleep_head = t;
			else sleep_link[prev] = t;
			sleep_count++;
			flags[t][FLAG_DELAYED] = 1'b1;
		endfunction

		function void advance_tick();
			logic [3:0] h;
			if (sleep_count > 0) begin
				h = sleep_head;
				if (sleep_delta[h] > 0) sleep_delta[h]--;
				while (sleep_count > 0) begin
					h = sleep_head;
					if (sleep_delta[h] != 0) break;
					sleep_head = sleep_link[h];
					sleep_count--;
					flags[h][FLAG_DELAYED] = 1'b0;
					enqueue(h);
				end
			end
			if (flags[running][FLAG_VALID]) begin
				slice[running] = slice[running] - 8'd1;
				if (slice[running] == 0) begin
					slice[running] = slice_len;
					if (!flags[running][FLAG_DELAYED] && !flags[running][FLAG_SUSPENDED]) begin
						dequeue(running);
						enqueue(running);
					end
				end
			end
		endfunction

		function void note_event(action_t act, logic [3:0] tid, logic [4:0] pr,
				logic [31:0] ticks);
			sched_result_t r;
			logic sched;
			sched = 1'b0;
			case (act)
				ACT_ADD: begin
					if (!flags[tid][FLAG_VALID]) begin
						prio[tid] = pr;
						flags[tid] = '0;
						flags[tid][FLAG_VALID] = 1'b1;
						susp[tid] = '0;
						slice[tid] = slice_len;
						sleep_delta[tid] = '0;
						enqueue(tid);
					end
				end
				ACT_TICK: begin
					advance_tick();
					sched = 1'b1;
				end
				ACT_DELAY: begin
					if (flags[running][FLAG_VALID] && !flags[running][FLAG_DELAYED]
							&& !flags[running][FLAG_SUSPENDED]) begin
						sleep_insert(running, ticks);
						dequeue(running);
					end
					sched = 1'b1;
				end
				ACT_SUSPEND: begin
					if (flags[tid][FLAG_VALID] && !flags[tid][FLAG_DELAYED]) begin
						if (susp[tid] < SAT_MAX) susp[tid]++;
						if (susp[tid] == 1) begin
							flags[tid][FLAG_SUSPENDED] = 1'b1;
							dequeue(tid);
							if (tid == running) sched = 1'b1;
						end
					end
				end
				ACT_WAKE: begin
					if (flags[tid][FLAG_SUSPENDED]) begin
						if (susp[tid] > 0) susp[tid]--;
						if (susp[tid] == 0) begin
							flags[tid][FLAG_SUSPENDED] = 1'b0;
							enqueue(tid);
							sched = 1'b1;
						end
					end
				end
				ACT_LOCK: begin
					if (locks < SAT_MAX) locks++;
				end
				ACT_UNLOCK: begin
					if (locks > 0) begin
						locks--;
						if (locks == 0) sched = 1'b1;
					end
				end
				default: ;
			endcase
			r.next_task = running;
			r.switch_request = 1'b0;
			r.none_ready = (bitmap == 0);
			if (bitmap != 0) begin
				for (int p = 31; p >= 0; p--)
					if (bitmap[p]) r.next_task = q_head[p];
				if (sched && locks == 0 && r.next_task != running) begin
					r.switch_request = 1'b1;
					running = r.next_task;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [3:0] nt, logic sw, logic nr);
			sched_result_t e;
			results_seen++;
			if (sw) switches_seen++;
			if (pending.size() == 0) begin
				$display("%0t: result with nothing expected: next_task=%0d switch=%0b none=%0b",
					$time, nt, sw, nr);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (nt !== e.next_task) begin
				$display("%0t: next_task expected %0d actual %0d", $time, e.next_task, nt);
				errors++;
			end
			if (sw !== e.switch_request) begin
				$display("%0t: switch_request expected %0b actual %0b", $time,
					e.switch_request, sw);
				errors++;
			end
			if (nr !== e.none_ready) begin
				$display("%0t: none_ready expected %0b actual %0b", $time, e.none_ready, nr);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  action;
	logic [3:0]  task_id;
	logic [4:0]  priority_req;
	logic [31:0] delay_ticks;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  next_task;
	logic        switch_request;
	logic        none_ready;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;

	sched_scoreboard sb;
	bit no_gaps;
	int events_sent;

	priority_task_scheduler u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .task_id(task_id), .priority_req(priority_req),
		.delay_ticks(delay_ticks),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_task(next_task), .switch_request(switch_request), .none_ready(none_ready),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_event(action_t act, logic [3:0] tid, logic [4:0] pr, logic [31:0] ticks);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		task_id <= tid;
		priority_req <= pr;
		delay_ticks <= ticks;
		do @(posedge clk); while (!in_ready);
		sb.note_event(act, tid, pr, ticks);
		events_sent++;
	endtask

	// Waits for every outstanding result, then writes the slice length with the block idle.
	task automatic write_slice(logic [7:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_slice(v);
	endtask

	task automatic random_events(int n);
		action_t act;
		int w;
		logic [4:0] pr;
		logic [31:0] ticks;
		for (int i = 0; i < n; i++) begin
			w = $urandom_range(0, 99);
			if (w < 14) act = ACT_ADD;
			else if (w < 50) act = ACT_TICK;
			else if (w < 62) act = ACT_DELAY;
			else if (w < 72) act = ACT_SUSPEND;
			else if (w < 84) act = ACT_WAKE;
			else if (w < 90) act = ACT_LOCK;
			else if (w < 98) act = ACT_UNLOCK;
			else act = ACT_NONE;
			// Few priorities keep queues shared, so rotation and FIFO order get exercised.
			pr = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
			w = $urandom_range(0, 99);
			if (w < 2) ticks = $urandom;
			else if (w < 10) ticks = $urandom_range(0, 60);
			else ticks = $urandom_range(0, 8);
			send_event(act, 4'($urandom), pr, ticks);
		end
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(next_task, switch_request, none_ready);
		end
	end

	initial begin
		#5ms;
		$display("Timeout waiting for the scheduler");
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int guard;
		sb = new();
		no_gaps = 1'b0;
		events_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0;
		task_id = '0;
		priority_req = '0;
		delay_ticks = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_slice(8'd3);
		// Directed: empty scheduler, extremes of fields, and the ignored cases.
		send_event(ACT_TICK, 4'd0, 5'd0, 32'd0);
		send_event(ACT_DELAY, 4'd0, 5'd0, 32'd5);
		send_event(ACT_NONE, 4'd9, 5'd9, 32'hFFFF_FFFF);
		send_event(ACT_WAKE, 4'd3, 5'd0, 32'd0);
		send_event(ACT_ADD, 4'd15, 5'd31, 32'd0);
		send_event(ACT_TICK, 4'd0, 5'd0, 32'd0);
		send_event(ACT_ADD, 4'd0, 5'd0, 32'd0);
		send_event(ACT_ADD, 4'd0, 5'd7, 32'd0);
		send_event(ACT_ADD, 4'd1, 5'd0, 32'd0);
		send_event(ACT_TICK, 4'd0, 5'd0, 32'd0);
		send_event(ACT_DELAY, 4'd0, 5'd0, 32'd0);
		send_event(ACT_TICK, 4'd0, 5'd0, 32'd0);
		send_event(ACT_DELAY, 4'd0, 5'd0, 32'hFFFF_FFFF);
		send_event(ACT_SUSPEND, 4'd15, 5'd0, 32'd0);
		send_event(ACT_SUSPEND, 4'd1, 5'd0, 32'd0);
		send_event(ACT_SUSPEND, 4'd1, 5'd0, 32'd0);
		send_event(ACT_WAKE, 4'd1, 5'd0, 32'd0);
		send_event(ACT_LOCK, 4'd0, 5'd0, 32'd0);
		send_event(ACT_WAKE, 4'd1, 5'd0, 32'd0);
		send_event(ACT_TICK, 4'd0, 5'd0, 32'd0);
		send_event(ACT_UNLOCK, 4'd0, 5'd0, 32'd0);
		send_event(ACT_UNLOCK, 4'd0, 5'd0, 32'd0);
		send_event(ACT_SUSPEND, 4'd7, 5'd0, 32'd0);
		send_event(ACT_DELAY, 4'd0, 5'd0, 32'h8000_0000);

		write_slice(8'd1);
		random_events(150);

		// Saturation of the lock count.
		write_slice(8'd255);
		send_event(ACT_ADD, 4'd12, 5'd2, 32'd0);
		for (int i = 0; i < 257; i++) send_event(ACT_LOCK, 4'd0, 5'd0, 32'd0);
		send_event(ACT_TICK, 4'd0, 5'd0, 32'd0);
		for (int i = 0; i < 257; i++) send_event(ACT_UNLOCK, 4'd0, 5'd0, 32'd0);

		write_slice(8'd0);
		random_events(100);
		write_slice(8'd2);
		no_gaps = 1'b1;
		random_events(80);
		no_gaps = 1'b0;
		random_events(80);

		in_valid <= 1'b0;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.pending.size());
			sb.errors++;
		end
		$display("Ran %0d scheduler events over five slice settings, including lock", events_sent);
		$display("saturation; %0d results checked, %0d with a switch.",
			sb.results_seen, sb.switches_seen);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
